@@ hw/rtl/mlfq_pkg.sv @@
// Shared types and constants for the multilevel feedback queue scheduler.
// Used by mlfq_ctrl, mlfq_dp and mlfq_scheduler_core; no dependencies.
package mlfq_pkg;

   localparam int PID_W    = 16;
   localparam int ALLOT_W  = 4;
   localparam int DEMOTE_W = 4;
   localparam int BOOST_W  = 8;
   localparam int CSR_W    = 8;
   localparam int LVL_OUT_W = 2;

   localparam logic [ALLOT_W-1:0]  ALLOT_MAX     = 4'd15;
   localparam logic [DEMOTE_W-1:0] DEMOTE_RESET  = 4'd2;
   localparam logic [BOOST_W-1:0]  BOOST_RESET   = 8'd10;

   localparam logic CSR_DEMOTE_TICKS = 1'b0;
   localparam logic CSR_BOOST_PERIOD = 1'b1;

   localparam logic OP_ADMIT = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_ADM_RD   = 8'b0000_0010,
      ST_ADM_WR   = 8'b0000_0100,
      ST_TK_CNT   = 8'b0000_1000,
      ST_TK_BOOST = 8'b0001_0000,
      ST_TK_RUN   = 8'b0010_0000,
      ST_TK_SWAP  = 8'b0100_0000,
      ST_DONE     = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic capture;
      logic adm_check;
      logic adm_write;
      logic tick_count;
      logic boost_step;
      logic run_step;
      logic swap;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic op_tick;
      logic full;
      logic boost_due;
      logic boost_last;
      logic dispatch;
      logic rsp_busy;
   } stat_type;

endpackage

@@ hw/rtl/mlfq_ctrl.sv @@
// Sequencer for the scheduler: walks admit and tick items through the datapath.
// Depends on mlfq_pkg for the state, command and status types.
module mlfq_ctrl
   import mlfq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = stat.op_tick ? ST_TK_CNT : ST_ADM_RD;
            end
         end
         ST_ADM_RD: begin
            cmd.adm_check = 1'b1;
            state_in      = stat.full ? ST_DONE : ST_ADM_WR;
         end
         ST_ADM_WR: begin
            cmd.adm_write = 1'b1;
            state_in      = ST_DONE;
         end
         ST_TK_CNT: begin
            cmd.tick_count = 1'b1;
            state_in       = stat.boost_due ? ST_TK_BOOST : ST_TK_RUN;
         end
         ST_TK_BOOST: begin
            cmd.boost_step = 1'b1;
            if (stat.boost_last) state_in = ST_TK_RUN;
         end
         ST_TK_RUN: begin
            cmd.run_step = 1'b1;
            state_in     = stat.dispatch ? ST_TK_SWAP : ST_DONE;
         end
         ST_TK_SWAP: begin
            cmd.swap = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

@@ hw/rtl/mlfq_dp.sv @@
// Datapath for the scheduler: entry memories, level queues, run state, result beat.
// Depends on mlfq_pkg for widths, register indexes and command/status types.
module mlfq_dp
   import mlfq_pkg::*;
#(
   parameter int MAX_PROCS  = 32,
   parameter int NUM_LEVELS = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  logic                 req_operation,
   input  logic [PID_W-1:0]     req_process_id,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [CSR_W-1:0]     csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_running_valid,
   output logic [PID_W-1:0]     rsp_running_pid,
   output logic [LVL_OUT_W-1:0] rsp_running_level,
   output logic                 rsp_switched,
   output logic [PID_W-1:0]     rsp_stopped_pid,
   output logic                 rsp_status
);

   localparam int PW  = $clog2(MAX_PROCS);
   localparam int CW  = $clog2(MAX_PROCS + 1);
   localparam int LIW = $clog2(NUM_LEVELS);
   localparam int LVW = $clog2(NUM_LEVELS + 1);
   localparam logic [LIW-1:0] TOP      = LIW'(NUM_LEVELS - 1);
   localparam logic [LIW-1:0] BOOST_LV = LIW'(NUM_LEVELS - 2);
   localparam logic [CW-1:0]  FULL_CNT = CW'(MAX_PROCS);

   logic [PID_W-1:0]   pid_mem   [MAX_PROCS];
   logic [ALLOT_W-1:0] allot_mem [MAX_PROCS];
   logic [PW-1:0]      next_mem  [MAX_PROCS];
   logic [PW-1:0]      free_mem  [MAX_PROCS];

   logic [PW-1:0] head_ff  [NUM_LEVELS];
   logic [PW-1:0] head_in  [NUM_LEVELS];
   logic [PW-1:0] tail_ff  [NUM_LEVELS];
   logic [PW-1:0] tail_in  [NUM_LEVELS];
   logic [CW-1:0] count_ff [NUM_LEVELS];
   logic [CW-1:0] count_in [NUM_LEVELS];

   logic [CW-1:0] used_ff, used_in, sp_ff, sp_in, hwm_ff, hwm_in;

   logic [PID_W-1:0]    run_pid_ff;
   logic [LVW-1:0]      run_level_ff;
   logic [ALLOT_W-1:0]  run_allot_ff;
   logic                run_valid_ff;
   logic [BOOST_W-1:0]  boost_count_ff;
   logic [DEMOTE_W-1:0] demote_ticks_ff;
   logic [BOOST_W-1:0]  boost_period_ff;
   logic [LIW-1:0]      boost_lv_ff;
   logic [LIW-1:0]      best_ff;

   logic [PID_W-1:0]   pid_ff;
   logic               switched_ff, status_ff;
   logic [PID_W-1:0]   stopped_ff;

   logic [PID_W-1:0]   pid_rd_ff;
   logic [ALLOT_W-1:0] allot_rd_ff;
   logic [PW-1:0]      next_rd_ff;
   logic [PW-1:0]      free_rd_ff;

   logic               rsp_valid_ff;
   logic               rsp_rv_ff, rsp_sw_ff, rsp_st_ff;
   logic [PID_W-1:0]   rsp_pid_ff, rsp_stop_ff;
   logic [LVL_OUT_W-1:0] rsp_lvl_ff;

   logic [BOOST_W-1:0] bc_inc;
   logic               boost_due_c;
   logic [ALLOT_W-1:0] new_allot;
   logic [LVW-1:0]     new_level;
   logic [LIW-1:0]     best_c;
   logic               found_c, dispatch_c, demote_c;

   logic               next_we;
   logic [PW-1:0]      next_wa, next_wd;
   logic               ent_we;
   logic [PW-1:0]      ent_wa;
   logic [PID_W-1:0]   ent_pid_wd;
   logic [ALLOT_W-1:0] ent_allot_wd;
   logic               free_we;
   logic [PW-1:0]      slot_c, swap_slot;
   logic [LIW-1:0]     rl_idx;
   logic [CW-1:0]      cnt_pop, cnt_rl;

   always_comb begin
      bc_inc      = boost_count_ff + BOOST_W'(1);
      boost_due_c = (bc_inc >= boost_period_ff);
      new_allot   = (run_allot_ff < ALLOT_MAX) ? run_allot_ff + ALLOT_W'(1) : run_allot_ff;
      new_level   = run_level_ff;
      demote_c    = run_valid_ff && (run_level_ff > LVW'(1)) && (new_allot >= demote_ticks_ff);
      if (!run_valid_ff) new_allot = run_allot_ff;
      if (demote_c) begin
         new_level = run_level_ff - LVW'(1);
         new_allot = '0;
      end
      best_c  = '0;
      found_c = 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (count_ff[i] != '0) begin
            best_c  = LIW'(i);
            found_c = 1'b1;
         end
      end
      dispatch_c = found_c && (!run_valid_ff || ((LVW'(best_c) + LVW'(1)) >= new_level));
   end

   always_comb begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
         head_in[i]  = head_ff[i];
         tail_in[i]  = tail_ff[i];
         count_in[i] = count_ff[i];
      end
      used_in      = used_ff;
      sp_in        = sp_ff;
      hwm_in       = hwm_ff;
      next_we      = 1'b0;
      next_wa      = tail_ff[TOP];
      next_wd      = '0;
      ent_we       = 1'b0;
      ent_wa       = '0;
      ent_pid_wd   = pid_ff;
      ent_allot_wd = '0;
      free_we      = 1'b0;
      slot_c       = (sp_ff != '0) ? free_rd_ff : hwm_ff[PW-1:0];
      swap_slot    = head_ff[best_ff];
      rl_idx       = LIW'(run_level_ff - LVW'(1));
      cnt_pop      = count_ff[best_ff] - CW'(1);
      cnt_rl       = (rl_idx == best_ff) ? cnt_pop : count_ff[rl_idx];

      if (cmd.adm_write) begin
         used_in = used_ff + CW'(1);
         if (sp_ff != '0) sp_in = sp_ff - CW'(1);
         else             hwm_in = hwm_ff + CW'(1);
         ent_we       = 1'b1;
         ent_wa       = slot_c;
         ent_pid_wd   = pid_ff;
         ent_allot_wd = '0;
         if (count_ff[TOP] == '0) begin
            head_in[TOP] = slot_c;
         end else begin
            next_we = 1'b1;
            next_wa = tail_ff[TOP];
            next_wd = slot_c;
         end
         tail_in[TOP]  = slot_c;
         count_in[TOP] = count_ff[TOP] + CW'(1);
      end

      if (cmd.boost_step && (count_ff[boost_lv_ff] != '0)) begin
         if (count_ff[TOP] == '0) begin
            head_in[TOP] = head_ff[boost_lv_ff];
         end else begin
            next_we = 1'b1;
            next_wa = tail_ff[TOP];
            next_wd = head_ff[boost_lv_ff];
         end
         tail_in[TOP]          = tail_ff[boost_lv_ff];
         count_in[TOP]         = count_ff[TOP] + count_ff[boost_lv_ff];
         count_in[boost_lv_ff] = '0;
         head_in[boost_lv_ff]  = '0;
         tail_in[boost_lv_ff]  = '0;
      end

      if (cmd.swap) begin
         head_in[best_ff]  = next_rd_ff;
         count_in[best_ff] = cnt_pop;
         if (run_valid_ff) begin
            ent_we       = 1'b1;
            ent_wa       = swap_slot;
            ent_pid_wd   = run_pid_ff;
            ent_allot_wd = run_allot_ff;
            if (cnt_rl == '0) begin
               head_in[rl_idx] = swap_slot;
            end else begin
               next_we = 1'b1;
               next_wa = tail_ff[rl_idx];
               next_wd = swap_slot;
            end
            tail_in[rl_idx]  = swap_slot;
            count_in[rl_idx] = cnt_rl + CW'(1);
         end else begin
            free_we = 1'b1;
            sp_in   = sp_ff + CW'(1);
            used_in = used_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         pid_mem[ent_wa]   <= ent_pid_wd;
         allot_mem[ent_wa] <= ent_allot_wd;
      end
      if (next_we) next_mem[next_wa] <= next_wd;
      if (free_we) free_mem[sp_ff[PW-1:0]] <= swap_slot;
      pid_rd_ff   <= pid_mem[head_ff[best_c]];
      allot_rd_ff <= allot_mem[head_ff[best_c]];
      next_rd_ff  <= next_mem[head_ff[best_c]];
      free_rd_ff  <= free_mem[PW'(sp_ff - CW'(1))];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         used_ff         <= '0;
         sp_ff           <= '0;
         hwm_ff          <= '0;
         run_pid_ff      <= '0;
         run_level_ff    <= LVW'(NUM_LEVELS);
         run_allot_ff    <= '0;
         run_valid_ff    <= 1'b0;
         boost_count_ff  <= '0;
         demote_ticks_ff <= DEMOTE_RESET;
         boost_period_ff <= BOOST_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i]  <= head_in[i];
            tail_ff[i]  <= tail_in[i];
            count_ff[i] <= count_in[i];
         end
         used_ff <= used_in;
         sp_ff   <= sp_in;
         hwm_ff  <= hwm_in;
         if (csr_we) begin
            if (csr_index == CSR_DEMOTE_TICKS) demote_ticks_ff <= csr_data[DEMOTE_W-1:0];
            if (csr_index == CSR_BOOST_PERIOD) boost_period_ff <= csr_data[BOOST_W-1:0];
         end
         if (cmd.tick_count) boost_count_ff <= boost_due_c ? '0 : bc_inc;
         if (cmd.run_step && run_valid_ff) begin
            run_allot_ff <= new_allot;
            run_level_ff <= new_level;
         end
         if (cmd.swap) begin
            run_pid_ff   <= pid_rd_ff;
            run_allot_ff <= allot_rd_ff;
            run_level_ff <= LVW'(best_ff) + LVW'(1);
            run_valid_ff <= 1'b1;
         end
         if (cmd.finish)      rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pid_ff      <= req_process_id;
         switched_ff <= 1'b0;
         stopped_ff  <= '0;
         status_ff   <= 1'b0;
      end
      if (cmd.adm_check && (used_ff == FULL_CNT)) status_ff <= 1'b1;
      if (cmd.tick_count) boost_lv_ff <= BOOST_LV;
      if (cmd.boost_step) boost_lv_ff <= boost_lv_ff - LIW'(1);
      if (cmd.run_step)   best_ff <= best_c;
      if (cmd.swap) begin
         switched_ff <= 1'b1;
         stopped_ff  <= run_valid_ff ? run_pid_ff : '0;
      end
      if (cmd.finish) begin
         rsp_rv_ff   <= run_valid_ff;
         rsp_pid_ff  <= run_valid_ff ? run_pid_ff : '0;
         rsp_lvl_ff  <= run_valid_ff ? run_level_ff[LVL_OUT_W-1:0] : '0;
         rsp_sw_ff   <= switched_ff;
         rsp_stop_ff <= stopped_ff;
         rsp_st_ff   <= status_ff;
      end
   end

   assign stat.op_tick    = (req_operation == OP_TICK);
   assign stat.full       = (used_ff == FULL_CNT);
   assign stat.boost_due  = boost_due_c;
   assign stat.boost_last = (boost_lv_ff == '0);
   assign stat.dispatch   = dispatch_c;
   assign stat.rsp_busy   = rsp_valid_ff && rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_running_valid = rsp_rv_ff;
   assign rsp_running_pid   = rsp_pid_ff;
   assign rsp_running_level = rsp_lvl_ff;
   assign rsp_switched      = rsp_sw_ff;
   assign rsp_stopped_pid   = rsp_stop_ff;
   assign rsp_status        = rsp_st_ff;

endmodule

@@ hw/rtl/mlfq_scheduler_core.sv @@
// Top level of the multilevel feedback queue scheduler: sequencer plus datapath.
// Depends on mlfq_pkg, mlfq_ctrl and mlfq_dp.
//
// One admit or tick beat is taken at a time. An admit checks for room, then
// writes the new entry at the tail of the top queue, or skips the write when
// the store is full. A tick counts toward the boost period, splices the lower
// queues onto the top queue one level a cycle when that period expires, and
// swaps in a queued process when one is dispatched. The entry and free-slot
// memories are read through registers, and the result waits in an output
// register. A new beat is accepted while the previous result still waits in
// the output register. Entry storage needs no clearing pass after reset.
module mlfq_scheduler_core
   import mlfq_pkg::*;
#(
   parameter int MAX_PROCS  = 32,
   parameter int NUM_LEVELS = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   input  logic [PID_W-1:0]     req_process_id,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [CSR_W-1:0]     csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_running_valid,
   output logic [PID_W-1:0]     rsp_running_pid,
   output logic [LVL_OUT_W-1:0] rsp_running_level,
   output logic                 rsp_switched,
   output logic [PID_W-1:0]     rsp_stopped_pid,
   output logic                 rsp_status
);

   cmd_type  cmd;
   stat_type stat;

   mlfq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   mlfq_dp #(
      .MAX_PROCS  (MAX_PROCS),
      .NUM_LEVELS (NUM_LEVELS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_operation),
      .req_process_id    (req_process_id),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_running_valid (rsp_running_valid),
      .rsp_running_pid   (rsp_running_pid),
      .rsp_running_level (rsp_running_level),
      .rsp_switched      (rsp_switched),
      .rsp_stopped_pid   (rsp_stopped_pid),
      .rsp_status        (rsp_status)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("sequencer took a beat but did not go busy");

   a_idle_pid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_running_valid) |-> (rsp_running_pid == '0))
      else $error("running pid set with no running process");

   a_stop_needs_switch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_switched) |-> (rsp_stopped_pid == '0))
      else $error("stopped pid set without a switch");

   a_refuse_no_switch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> !rsp_switched)
      else $error("refused admit reported a switch");

endmodule
